@@ hdl/cmeq_pkg.sv @@
// Shared types, constants and trigonometry tables of the cube-map to
// equirectangular sampler. No dependencies.
package cmeq_pkg;

   localparam int FACE_W     = 64;
   localparam int FACE_H     = 64;
   localparam int FACE_CNT   = 6;
   localparam int NCOL       = 4 * FACE_W - 1;
   localparam int NROW       = 3 * FACE_H - 1;
   localparam int FACE_WORDS = FACE_CNT * FACE_W * FACE_H;
   localparam int TEX_AW     = $clog2(FACE_WORDS);
   localparam int XW         = $clog2(FACE_W);
   localparam int YW         = $clog2(FACE_H);
   localparam int LON_N      = NCOL + 1;
   localparam int LAT_N      = NROW + 1;
   localparam int LON_AW     = $clog2(LON_N);
   localparam int LAT_AW     = $clog2(LAT_N);
   localparam int SPAN_W     = FACE_W - 1;
   localparam int SPAN_H     = FACE_H - 1;
   localparam int SPAN_MAX   = (SPAN_W > SPAN_H) ? SPAN_W : SPAN_H;
   localparam int QW         = $clog2(SPAN_MAX * 256 + 1);
   localparam int NUM_W      = 17;
   localparam int DVD_W      = NUM_W + QW;
   localparam int REQ_DEPTH  = 4;
   localparam int RSP_DEPTH  = 4;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [2:0] FACE_RIGHT  = 3'd0;
   localparam logic [2:0] FACE_LEFT   = 3'd1;
   localparam logic [2:0] FACE_BOTTOM = 3'd2;
   localparam logic [2:0] FACE_TOP    = 3'd3;
   localparam logic [2:0] FACE_FRONT  = 3'd4;
   localparam logic [2:0] FACE_BACK   = 3'd5;

   typedef struct packed {
      logic       req_type;
      logic [2:0] face_index;
      logic [5:0] tex_col;
      logic [5:0] tex_row;
      logic [7:0] load_red;
      logic [7:0] load_green;
      logic [7:0] load_blue;
      logic [7:0] pix_col;
      logic [7:0] pix_row;
   } cmeq_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [2:0] face_used;
   } cmeq_rsp_type;

   typedef struct packed {
      logic              is_sample;
      logic              wr_ok;
      logic [TEX_AW-1:0] addr;
      logic [23:0]       rgb;
   } cmeq_tag_type;

   typedef struct packed {
      cmeq_tag_type      tag;
      logic [LON_AW-1:0] col;
      logic [LAT_AW-1:0] row;
   } cmeq_item_type;

   typedef struct packed {
      cmeq_tag_type  tag;
      logic [2:0]    face;
      logic [QW-1:0] cu;
      logic [QW-1:0] cv;
   } cmeq_job_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_WR,
      FS_RD0,
      FS_RD1,
      FS_RD2,
      FS_RD3
   } cmeq_fetch_state_type;

   typedef logic signed [15:0] cmeq_q15_type;
   typedef cmeq_q15_type cmeq_lon_tab_type [LON_N];
   typedef cmeq_q15_type cmeq_lat_tab_type [LAT_N];

   // Quarter-wave polynomial, t in Q14, products truncated by 14 bits.
   function automatic int unsigned quarter_sin(int unsigned t);
      int unsigned t2;
      int unsigned inner;
      int unsigned mid;
      int unsigned r;
      t2    = (t * t) >> 14;
      inner = 21167 - ((t2 * 2611) >> 14);
      mid   = 51472 - ((t2 * inner) >> 14);
      r     = (t * mid) >> 14;
      return (r > 32767) ? 32767 : r;
   endfunction

   function automatic int sin_q15(int unsigned phase);
      int unsigned p;
      int unsigned r;
      int          s;
      p = phase & 32'hFFFF;
      r = p & 32'h3FFF;
      s = int'(p[14] ? quarter_sin(16384 - r) : quarter_sin(r));
      return p[15] ? -s : s;
   endfunction

   function automatic cmeq_lon_tab_type build_lon(bit cosine);
      cmeq_lon_tab_type tab;
      longint unsigned  ph;
      for (int c = 0; c < LON_N; c++) begin
         ph = ((longint'(c) << 16) + NCOL / 2) / NCOL;
         tab[c] = 16'(sin_q15(32'(ph & 64'hFFFF) + (cosine ? 32'd16384 : 32'd0)));
      end
      return tab;
   endfunction

   function automatic cmeq_lat_tab_type build_lat(bit cosine);
      cmeq_lat_tab_type tab;
      longint unsigned  ph;
      for (int r = 0; r < LAT_N; r++) begin
         ph = ((longint'(NROW - r) << 15) + NROW / 2) / NROW;
         tab[r] = 16'(sin_q15(32'(ph) + (cosine ? 32'd16384 : 32'd0)));
      end
      return tab;
   endfunction

   localparam cmeq_lon_tab_type LON_SIN = build_lon(1'b0);
   localparam cmeq_lon_tab_type LON_COS = build_lon(1'b1);
   localparam cmeq_lat_tab_type LAT_SIN = build_lat(1'b0);
   localparam cmeq_lat_tab_type LAT_COS = build_lat(1'b1);

endpackage

@@ hdl/cubemap_to_equirect_sampler.sv @@
// Top level of the cube-map to equirectangular sampler: front end, geometry
// pipeline and texel fetch back end. Depends on cmeq_pkg and the cmeq_ modules.
//
// The block keeps six 64x64 cube faces of 24-bit RGB texels and answers
// sample beats with the bilinear colour of one pixel of the 256x192
// equirectangular image, together with the face it came from. A load beat
// (req_type 0) writes one texel and returns nothing; a load with a face
// above 5 is dropped. A sample beat (req_type 1) returns one result beat,
// in request order. Both sides behave as queues: a request beat moves when
// push is high and full is low, a result beat when pop is high and empty is
// low. Sustained rate: one load per cycle while no sample holds the
// single-port face memory and the result queue has room; each sample needs
// four texel reads, and the next job is taken only during the last of them.
// Texel memory is not cleared at reset: read only texels that have been
// loaded.
module cubemap_to_equirect_sampler import cmeq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  cmeq_req_type req_data,
   output logic         empty,
   input  logic         pop,
   output cmeq_rsp_type rsp_data
);

   logic          item_vld, item_pop;
   cmeq_item_type item;
   logic          job_vld, job_take;
   cmeq_job_type  job;

   // Accept and classify beats; hold them in the request queue.
   cmeq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .item_vld (item_vld),
      .item_pop (item_pop),
      .item     (item)
   );

   // Direction, face choice and coordinate division; loads ride along
   // so memory writes stay in order with earlier samples.
   cmeq_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item_pop (item_pop),
      .item     (item),
      .job_vld  (job_vld),
      .job_take (job_take),
      .job      (job)
   );

   // Texel memory, four reads per sample, blend and result queue.
   cmeq_fetch u_fetch (
      .clock    (clock),
      .reset    (reset),
      .job_vld  (job_vld),
      .job_take (job_take),
      .job      (job),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ hdl/cmeq_front.sv @@
// Front end: accepts request beats, classifies them and holds them in a
// short queue for the back end. Depends on cmeq_pkg.
module cmeq_front import cmeq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  cmeq_req_type  req_data,
   output logic          item_vld,
   input  logic          item_pop,
   output cmeq_item_type item
);

   localparam int PW = $clog2(REQ_DEPTH);
   localparam int CW = $clog2(REQ_DEPTH + 1);

   cmeq_item_type q_ff [REQ_DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;
   cmeq_item_type cls;
   logic          do_push, do_pop;

   always_comb begin
      cls.tag.is_sample = req_data.req_type == REQ_SAMPLE;
      cls.tag.wr_ok     = (req_data.face_index < 3'(FACE_CNT)) &&
                          (32'(req_data.tex_col) < FACE_W) &&
                          (32'(req_data.tex_row) < FACE_H);
      cls.tag.addr      = TEX_AW'(req_data.face_index) * TEX_AW'(FACE_W * FACE_H) +
                          TEX_AW'(req_data.tex_row) * TEX_AW'(FACE_W) +
                          TEX_AW'(req_data.tex_col);
      cls.tag.rgb       = {req_data.load_red, req_data.load_green, req_data.load_blue};
      cls.col = (32'(req_data.pix_col) > NCOL) ? LON_AW'(NCOL) : LON_AW'(req_data.pix_col);
      cls.row = (32'(req_data.pix_row) > NROW) ? LAT_AW'(NROW) : LAT_AW'(req_data.pix_row);
   end

   assign full     = cnt_ff == CW'(REQ_DEPTH);
   assign item_vld = cnt_ff != '0;
   assign item     = q_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = item_pop && item_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(do_push) - CW'(do_pop);
      end
      if (do_push) q_ff[wp_ff] <= cls;
   end

endmodule

@@ hdl/cmeq_geom.sv @@
// Geometry pipeline: direction from trig tables, face choice and a
// pipelined restoring divider for the face coordinates. Depends on cmeq_pkg.
module cmeq_geom import cmeq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_vld,
   output logic          item_pop,
   input  cmeq_item_type item,
   output logic          job_vld,
   input  logic          job_take,
   output cmeq_job_type  job
);

   typedef struct packed {
      logic             v;
      cmeq_tag_type     tag;
      logic [2:0]       face;
      logic [NUM_W-1:0] d;
      logic [DVD_W-1:0] ru;
      logic [DVD_W-1:0] rv;
      logic [QW-1:0]    qu;
      logic [QW-1:0]    qv;
   } cmeq_div_type;

   logic en;

   logic                v1_ff, v2_ff, v3_ff;
   cmeq_tag_type        tag1_ff, tag2_ff, tag3_ff;
   logic signed [15:0]  sp1_ff, cp1_ff, st1_ff, ct1_ff;
   logic signed [15:0]  x2_ff, y2_ff, z2_ff;
   logic [2:0]          face3_ff;
   logic [NUM_W-1:0]    nu3_ff, nv3_ff, d3_ff;
   cmeq_div_type        ds_ff [QW+1];

   assign en       = !ds_ff[QW].v || job_take;
   assign item_pop = en && item_vld;
   assign job_vld  = ds_ff[QW].v;
   assign job      = '{tag: ds_ff[QW].tag, face: ds_ff[QW].face,
                       cu: ds_ff[QW].qu, cv: ds_ff[QW].qv};

   // Rounded Q15 product of magnitudes, negated for the view direction.
   function automatic logic signed [15:0] neg_mul(logic signed [15:0] a,
                                                  logic signed [15:0] b);
      logic [15:0] ma;
      logic [15:0] mb;
      logic [31:0] pr;
      logic [15:0] m;
      ma = a[15] ? 16'(-a) : 16'(a);
      mb = b[15] ? 16'(-b) : 16'(b);
      pr = 32'(ma) * 32'(mb) + 32'd16384;
      m  = pr[30:15];
      return (a[15] != b[15]) ? signed'(m) : signed'(16'(-m));
   endfunction

   function automatic logic [NUM_W-1:0] clamp_num(logic signed [17:0] n,
                                                  logic [NUM_W-1:0] two_a);
      if (n < 0)                           return '0;
      else if (n > signed'({1'b0, two_a})) return two_a;
      else                                 return n[NUM_W-1:0];
   endfunction

   // Direction lookup.
   always_ff @(posedge clock) begin
      if (reset)   v1_ff <= 1'b0;
      else if (en) v1_ff <= item_vld;
      if (en) begin
         tag1_ff <= item.tag;
         sp1_ff  <= LON_SIN[item.col];
         cp1_ff  <= LON_COS[item.col];
         st1_ff  <= LAT_SIN[item.row];
         ct1_ff  <= LAT_COS[item.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         tag2_ff <= tag1_ff;
         x2_ff   <= neg_mul(sp1_ff, st1_ff);
         y2_ff   <= ct1_ff;
         z2_ff   <= neg_mul(cp1_ff, st1_ff);
      end
   end

   // Face choice: greatest magnitude, ties to x then y.
   logic [15:0]        ax, ay, az, am;
   logic signed [17:0] xs, ys, zs, as;
   logic [NUM_W-1:0]   two_a;
   logic [2:0]         face_c;
   logic signed [17:0] nu_c, nv_c;

   always_comb begin
      ax = x2_ff[15] ? 16'(-x2_ff) : 16'(x2_ff);
      ay = y2_ff[15] ? 16'(-y2_ff) : 16'(y2_ff);
      az = z2_ff[15] ? 16'(-z2_ff) : 16'(z2_ff);
      xs = 18'(x2_ff);
      ys = 18'(y2_ff);
      zs = 18'(z2_ff);
      priority if (ax >= ay && ax >= az) begin
         am     = ax;
         face_c = x2_ff[15] ? FACE_LEFT : FACE_RIGHT;
         nu_c   = x2_ff[15] ? signed'(18'(am)) + zs : signed'(18'(am)) - zs;
         nv_c   = signed'(18'(am)) + ys;
      end else if (ay >= az) begin
         am     = ay;
         face_c = y2_ff[15] ? FACE_TOP : FACE_BOTTOM;
         nu_c   = signed'(18'(am)) + xs;
         nv_c   = y2_ff[15] ? signed'(18'(am)) + zs : signed'(18'(am)) - zs;
      end else begin
         am     = az;
         face_c = z2_ff[15] ? FACE_BACK : FACE_FRONT;
         nu_c   = z2_ff[15] ? signed'(18'(am)) - xs : signed'(18'(am)) + xs;
         nv_c   = signed'(18'(am)) + ys;
      end
      if (am == '0) begin
         // all components zero: fall back to a unit magnitude
         nu_c = nu_c + 18'sd1;
         nv_c = nv_c + 18'sd1;
         am   = 16'd1;
      end
      as    = signed'(18'(am));
      two_a = NUM_W'(am) << 1;
   end

   always_ff @(posedge clock) begin
      if (reset)   v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         tag3_ff  <= tag2_ff;
         face3_ff <= face_c;
         nu3_ff   <= clamp_num(nu_c, two_a);
         nv3_ff   <= clamp_num(nv_c, two_a);
         d3_ff    <= NUM_W'(as) << 1;
      end
   end

   // Scale the numerators by span in Q8 to form the dividends.
   always_ff @(posedge clock) begin
      if (reset)   ds_ff[0].v <= 1'b0;
      else if (en) ds_ff[0].v <= v3_ff;
      if (en) begin
         ds_ff[0].tag  <= tag3_ff;
         ds_ff[0].face <= face3_ff;
         ds_ff[0].d    <= d3_ff;
         ds_ff[0].ru   <= DVD_W'(nu3_ff) * DVD_W'(SPAN_W * 256);
         ds_ff[0].rv   <= DVD_W'(nv3_ff) * DVD_W'(SPAN_H * 256);
         ds_ff[0].qu   <= '0;
         ds_ff[0].qv   <= '0;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int B = QW - 1 - j;
      logic [DVD_W-1:0] sub_d;
      logic             ge_u, ge_v;
      assign sub_d = DVD_W'(ds_ff[j].d) << B;
      assign ge_u  = ds_ff[j].ru >= sub_d;
      assign ge_v  = ds_ff[j].rv >= sub_d;
      always_ff @(posedge clock) begin
         if (reset)   ds_ff[j+1].v <= 1'b0;
         else if (en) ds_ff[j+1].v <= ds_ff[j].v;
         if (en) begin
            ds_ff[j+1].tag  <= ds_ff[j].tag;
            ds_ff[j+1].face <= ds_ff[j].face;
            ds_ff[j+1].d    <= ds_ff[j].d;
            ds_ff[j+1].ru   <= ge_u ? ds_ff[j].ru - sub_d : ds_ff[j].ru;
            ds_ff[j+1].rv   <= ge_v ? ds_ff[j].rv - sub_d : ds_ff[j].rv;
            ds_ff[j+1].qu   <= ds_ff[j].qu | (QW'(ge_u) << B);
            ds_ff[j+1].qv   <= ds_ff[j].qv | (QW'(ge_v) << B);
         end
      end
   end

endmodule

@@ hdl/cmeq_fetch.sv @@
// Back end: face texel memory, four-read sequencer, bilinear blend and
// result queue. Depends on cmeq_pkg.
module cmeq_fetch import cmeq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_vld,
   output logic         job_take,
   input  cmeq_job_type job,
   output logic         empty,
   input  logic         pop,
   output cmeq_rsp_type rsp_data
);

   localparam int OPW = $clog2(RSP_DEPTH);
   localparam int OCW = $clog2(RSP_DEPTH + 1);
   localparam int XQ  = QW - 8;

   typedef struct packed {
      cmeq_tag_type      tag;
      logic [2:0]        face;
      logic [TEX_AW-1:0] base;
      logic [XW-1:0]     x0, x1;
      logic [YW-1:0]     y0, y1;
      logic [7:0]        fx, fy;
   } cmeq_cur_type;

   cmeq_fetch_state_type state_ff, state_in;
   cmeq_cur_type         cur_ff, cur_in;
   logic [23:0]          mem [FACE_WORDS];
   logic [23:0]          rdata_ff;
   logic [23:0]          p_ff [3];
   logic                 cap_vld_ff;
   logic [1:0]           cap_idx_ff;
   logic                 can_take, mem_re, mem_we;
   logic [1:0]           corner;
   logic [XW-1:0]        rx;
   logic [YW-1:0]        ry;
   logic [TEX_AW-1:0]    raddr;
   logic [OCW-1:0]       used_ff, cnt_ff;
   logic [OPW-1:0]       wp_ff, rp_ff;
   cmeq_rsp_type         of_ff [RSP_DEPTH];
   logic                 do_pop;

   // Split the Q8 coordinates, clamp the far neighbour at the face edge.
   always_comb begin
      logic [XQ-1:0] xi;
      logic [XQ-1:0] yi;
      xi             = job.cu[QW-1:8];
      yi             = job.cv[QW-1:8];
      cur_in.tag     = job.tag;
      cur_in.face    = job.face;
      cur_in.base    = TEX_AW'(job.face) * TEX_AW'(FACE_W * FACE_H);
      cur_in.fx      = job.cu[7:0];
      cur_in.fy      = job.cv[7:0];
      if (32'(xi) > SPAN_W) begin
         cur_in.x0 = XW'(SPAN_W);
         cur_in.fx = '0;
      end else begin
         cur_in.x0 = XW'(xi);
      end
      if (32'(yi) > SPAN_H) begin
         cur_in.y0 = YW'(SPAN_H);
         cur_in.fy = '0;
      end else begin
         cur_in.y0 = YW'(yi);
      end
      cur_in.x1 = (32'(cur_in.x0) < SPAN_W) ? cur_in.x0 + 1'b1 : cur_in.x0;
      cur_in.y1 = (32'(cur_in.y0) < SPAN_H) ? cur_in.y0 + 1'b1 : cur_in.y0;
   end

   assign can_take = (state_ff == FS_IDLE || state_ff == FS_WR || state_ff == FS_RD3) &&
                     (used_ff < OCW'(RSP_DEPTH));
   assign job_take = job_vld && can_take;

   always_comb begin
      state_in = FS_IDLE;
      if (job_take) begin
         state_in = job.tag.is_sample ? FS_RD0 : FS_WR;
      end else begin
         unique case (state_ff)
            FS_RD0:  state_in = FS_RD1;
            FS_RD1:  state_in = FS_RD2;
            FS_RD2:  state_in = FS_RD3;
            default: state_in = FS_IDLE;
         endcase
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      corner = 2'd0;
      unique case (state_ff)
         FS_WR:  mem_we = cur_ff.tag.wr_ok;
         FS_RD0: begin mem_re = 1'b1; corner = 2'd0; end
         FS_RD1: begin mem_re = 1'b1; corner = 2'd1; end
         FS_RD2: begin mem_re = 1'b1; corner = 2'd2; end
         FS_RD3: begin mem_re = 1'b1; corner = 2'd3; end
         default: ;
      endcase
   end

   // Corner order: (x0,y0) (x0,y1) (x1,y0) (x1,y1).
   assign rx    = corner[1] ? cur_ff.x1 : cur_ff.x0;
   assign ry    = corner[0] ? cur_ff.y1 : cur_ff.y0;
   assign raddr = cur_ff.base + TEX_AW'(ry) * TEX_AW'(FACE_W) + TEX_AW'(rx);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FS_IDLE;
      else       state_ff <= state_in;
      if (job_take) cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[cur_ff.tag.addr] <= cur_ff.tag.rgb;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) cap_vld_ff <= 1'b0;
      else       cap_vld_ff <= mem_re;
      cap_idx_ff <= corner;
      if (cap_vld_ff && cap_idx_ff != 2'd3) p_ff[cap_idx_ff] <= rdata_ff;
   end

   // Blend, first pass: horizontal pairs.
   logic        b1_go_ff, b2_go_ff;
   logic [7:0]  b1_fx_ff, b1_fy_ff, b2_fy_ff;
   logic [2:0]  b1_face_ff, b2_face_ff;
   logic [16:0] b2_d_ff [3];
   logic [16:0] b2_e_ff [3];
   logic [8:0]  wx, wy;

   always_ff @(posedge clock) begin
      if (reset) b1_go_ff <= 1'b0;
      else       b1_go_ff <= state_ff == FS_RD3;
      if (state_ff == FS_RD3) begin
         b1_fx_ff   <= cur_ff.fx;
         b1_fy_ff   <= cur_ff.fy;
         b1_face_ff <= cur_ff.face;
      end
   end

   assign wx = 9'd256 - 9'(b1_fx_ff);
   assign wy = 9'd256 - 9'(b2_fy_ff);

   for (genvar k = 0; k < 3; k++) begin : g_chan
      localparam int SH = 16 - 8 * k;
      logic [7:0]  c0, c1, c2, c3;
      logic [25:0] vs;
      assign c0 = p_ff[0][SH+7:SH];
      assign c1 = p_ff[1][SH+7:SH];
      assign c2 = p_ff[2][SH+7:SH];
      assign c3 = rdata_ff[SH+7:SH];
      always_ff @(posedge clock) begin
         if (b1_go_ff) begin
            b2_d_ff[k] <= 17'(c0) * 17'(wx) + 17'(c2) * 17'(b1_fx_ff);
            b2_e_ff[k] <= 17'(c1) * 17'(wx) + 17'(c3) * 17'(b1_fx_ff);
         end
      end
      assign vs = 26'(b2_d_ff[k]) * 26'(wy) + 26'(b2_e_ff[k]) * 26'(b2_fy_ff) + 26'd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) b2_go_ff <= 1'b0;
      else       b2_go_ff <= b1_go_ff;
      if (b1_go_ff) begin
         b2_fy_ff   <= b1_fy_ff;
         b2_face_ff <= b1_face_ff;
      end
   end

   function automatic logic [7:0] sat8(logic [25:0] v);
      return (v[25:16] > 10'd255) ? 8'd255 : v[23:16];
   endfunction

   // Result queue; used_ff reserves a slot when a sample is taken.
   assign empty    = cnt_ff == '0;
   assign rsp_data = of_ff[rp_ff];
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cnt_ff  <= '0;
         wp_ff   <= '0;
         rp_ff   <= '0;
      end else begin
         used_ff <= used_ff + OCW'(job_take && job.tag.is_sample) - OCW'(do_pop);
         cnt_ff  <= cnt_ff + OCW'(b2_go_ff) - OCW'(do_pop);
         if (b2_go_ff) wp_ff <= wp_ff + 1'b1;
         if (do_pop)   rp_ff <= rp_ff + 1'b1;
      end
      if (b2_go_ff) begin
         of_ff[wp_ff] <= '{out_red:   sat8(g_chan[0].vs),
                           out_green: sat8(g_chan[1].vs),
                           out_blue:  sat8(g_chan[2].vs),
                           face_used: b2_face_ff};
      end
   end

endmodule
